FILE: rtl/bpa_pkg.sv
// Package for the buddy page allocator: status codes, opcodes, node bit
// positions and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bpa_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOSPACE  = 2'd1,
    ST_NOTFOUND = 2'd2
  } bpa_status_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // bit positions in one node word
  localparam int BIT_ALLOC = 0;
  localparam int BIT_SPLIT = 1;
  localparam int BIT_HEAD  = 2;

  typedef struct packed {
    logic        clr_wr;
    logic        load;
    logic        rd_scan;
    logic        scan_next;
    logic        hit_save;
    logic        sweep_wr;
    logic        anc_init;
    logic        anc_wr;
    logic        rd_sib;
    logic        merge_wr;
    logic        res_load;
    bpa_status_t res_status;
  } bpa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic ord_big;
    logic op_alloc;
    logic scan_hit;
    logic scan_last;
    logic sweep_last;
    logic ptr_zero;
    logic sib_busy;
  } bpa_sts_t;

endpackage
`default_nettype wire

FILE: rtl/bpa_if.sv
// Request and response channel interfaces of the buddy page allocator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
interface bpa_req_if;
  logic        valid;
  logic        ready;
  logic        operation;
  logic [3:0]  order;
  logic [47:0] free_address;
  modport source (output valid, operation, order, free_address, input ready);
  modport sink (input valid, operation, order, free_address, output ready);
endinterface

interface bpa_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [47:0] block_address;
  logic [3:0]  freed_order;
  modport source (output valid, status, block_address, freed_order, input ready);
  modport sink (input valid, status, block_address, freed_order, output ready);
endinterface
`default_nettype wire

FILE: rtl/buddy_page_allocator_core.sv
// Top level of the buddy page allocator: APB register, sequencer and datapath.
// Depends on bpa_pkg, bpa_if, bpa_ctrl and bpa_datapath.
//
//   channel  dir  handshake      beat
//   req      in   valid/ready    operation, order, free_address
//   rsp      out  valid/ready    status, block_address, freed_order
//   apb      in   psel/penable   base_address at paddr 0, 64-bit data
//
// After reset a clearing pass writes all 2^(MAX_LEVEL+1) node words, one per
// cycle, with req.ready low; APB writes are taken throughout.
// Allocate: tries each node at the order's level (up to 2^(MAX_LEVEL-order)),
// then sweeps the 2^(order+1)-1 subtree nodes and marks the MAX_LEVEL-order
// ancestors. Free: scans up to 2^(MAX_LEVEL+1)-1 nodes, sweeps the subtree
// and merges level by level. A result waits in the output register while
// the next beat is taken.
`timescale 1ns / 1ps
`default_nettype none
module buddy_page_allocator_core #(
  parameter int MAX_LEVEL  = 8,
  parameter int PAGE_SHIFT = 12,
  parameter int ADDR_WIDTH = 48
) (
  input  logic        clk,
  input  logic        rst,
  bpa_req_if.sink     req,
  bpa_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import bpa_pkg::*;

  logic [47:0] base_address;
  bpa_cmd_t    cmd;
  bpa_sts_t    sts;

  assign pready = 1'b1;
  assign prdata = (paddr[3] == 1'b0) ? 64'(base_address) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= '0;
    end else if (psel && penable && pwrite && paddr[3] == 1'b0) begin
      base_address <= pwdata[47:0];
    end
  end

  bpa_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (req.valid),
    .in_operation (req.operation),
    .in_ready     (req.ready),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  bpa_datapath #(
    .MAX_LEVEL  (MAX_LEVEL),
    .PAGE_SHIFT (PAGE_SHIFT),
    .ADDR_WIDTH (ADDR_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .base_address    (base_address),
    .in_operation    (req.operation),
    .in_order        (req.order),
    .in_free_address (req.free_address),
    .status          (rsp.status),
    .block_address   (rsp.block_address),
    .freed_order     (rsp.freed_order)
  );

endmodule
`default_nettype wire

FILE: rtl/bpa_ctrl.sv
// Sequencer of the buddy page allocator: clear pass, tree scan, subtree
// sweep, ancestor marking and merge walk. Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bpa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_operation,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bpa_pkg::bpa_sts_t sts,
  output bpa_pkg::bpa_cmd_t cmd
);
  import bpa_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_RD, S_CHK, S_SWEEP, S_ANC, S_MRD, S_MCHK, S_DONE
  } state_t;

  state_t      state, state_next;
  bpa_status_t st_q, st_q_next;
  logic        out_valid_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    st_q_next      = st_q;
    out_valid_next = out_valid && !out_ready;
    case (state)
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (in_operation == OP_ALLOC && sts.ord_big) begin
            st_q_next  = ST_NOSPACE;
            state_next = S_DONE;
          end else begin
            state_next = S_RD;
          end
        end
      end
      S_RD: begin
        cmd.rd_scan = 1'b1;
        state_next  = S_CHK;
      end
      S_CHK: begin
        if (sts.scan_hit) begin
          cmd.hit_save = 1'b1;
          state_next   = S_SWEEP;
        end else if (sts.scan_last) begin
          st_q_next  = sts.op_alloc ? ST_NOSPACE : ST_NOTFOUND;
          state_next = S_DONE;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_RD;
        end
      end
      S_SWEEP: begin
        cmd.sweep_wr = 1'b1;
        if (sts.sweep_last) begin
          cmd.anc_init = 1'b1;
          state_next   = sts.op_alloc ? S_ANC : S_MRD;
        end
      end
      S_ANC: begin
        if (sts.ptr_zero) begin
          st_q_next  = ST_OK;
          state_next = S_DONE;
        end else begin
          cmd.anc_wr = 1'b1;
        end
      end
      S_MRD: begin
        if (sts.ptr_zero) begin
          st_q_next  = ST_OK;
          state_next = S_DONE;
        end else begin
          cmd.rd_sib = 1'b1;
          state_next = S_MCHK;
        end
      end
      S_MCHK: begin
        if (sts.sib_busy) begin
          st_q_next  = ST_OK;
          state_next = S_DONE;
        end else begin
          cmd.merge_wr = 1'b1;
          state_next   = S_MRD;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = st_q;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      st_q      <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      st_q      <= st_q_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/bpa_datapath.sv
// Datapath of the buddy page allocator: node memory, scan and sweep
// pointers, address generation and result registers. Depends on bpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bpa_datapath #(
  parameter int MAX_LEVEL  = 8,
  parameter int PAGE_SHIFT = 12,
  parameter int ADDR_WIDTH = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  bpa_pkg::bpa_cmd_t cmd,
  output bpa_pkg::bpa_sts_t sts,
  input  logic [47:0]       base_address,
  input  logic              in_operation,
  input  logic [3:0]        in_order,
  input  logic [47:0]       in_free_address,
  output logic [1:0]        status,
  output logic [47:0]       block_address,
  output logic [3:0]        freed_order
);
  import bpa_pkg::*;

  localparam int NW    = MAX_LEVEL + 1;
  localparam int NODES = 1 << NW;
  localparam int DW    = $clog2(MAX_LEVEL + 1);
  localparam int SW    = MAX_LEVEL + PAGE_SHIFT + 1;
  localparam int AW    = ADDR_WIDTH;

  // node word: {head, split, allocated}, heap numbering, slot 0 unused
  logic [2:0]    mem [NODES];
  logic [2:0]    rdata;
  logic [NW-1:0] idx, hn, sw_idx, sw_start, sw_end, ptr, cur;
  logic [DW-1:0] depth, hit_depth;
  logic [AW-1:0] off;
  logic [SW-1:0] step;
  logic          op_q;
  logic [47:0]   faddr_q, hit_addr;

  logic [AW-1:0] sum;
  logic [47:0]   node_addr;
  logic [DW-1:0] ld_depth;
  logic          we, re;
  logic [NW-1:0] waddr, raddr;
  logic [2:0]    wdata;
  logic [2:0]    sweep_data;
  logic          level_end;

  assign sum       = AW'(base_address) + off;
  assign node_addr = 48'(sum);
  assign ld_depth  = DW'(MAX_LEVEL) - DW'(in_order);

  // last node of the current tree level
  assign level_end = ((idx & (idx + NW'(1))) == '0);

  assign sts.clr_last   = &idx;
  assign sts.ord_big    = (int'(in_order) > MAX_LEVEL);
  assign sts.op_alloc   = (op_q == OP_ALLOC);
  // allocate scans one level, free scans the whole tree
  assign sts.scan_last  = level_end && ((op_q == OP_ALLOC) || idx[NW-1]);
  assign sts.scan_hit   = (op_q == OP_ALLOC) ?
                          (!rdata[BIT_ALLOC] && !rdata[BIT_SPLIT]) :
                          (rdata[BIT_HEAD] && node_addr == faddr_q);
  assign sts.sweep_last = (sw_idx == sw_end) && sw_end[NW-1];
  assign sts.ptr_zero   = (ptr == '0);
  assign sts.sib_busy   = rdata[BIT_ALLOC] | rdata[BIT_SPLIT];

  always_comb begin
    sweep_data            = '0;
    sweep_data[BIT_ALLOC] = (op_q == OP_ALLOC);
    sweep_data[BIT_HEAD]  = (op_q == OP_ALLOC) && (sw_idx == hn);
  end

  always_comb begin
    we    = 1'b0;
    waddr = idx;
    wdata = '0;
    if (cmd.clr_wr) begin
      we = 1'b1;
    end else if (cmd.sweep_wr) begin
      we    = 1'b1;
      waddr = sw_idx;
      wdata = sweep_data;
    end else if (cmd.anc_wr) begin
      we              = 1'b1;
      waddr           = ptr;
      wdata[BIT_SPLIT] = 1'b1;
    end else if (cmd.merge_wr) begin
      we    = 1'b1;
      waddr = ptr;
    end
    re    = cmd.rd_scan | cmd.rd_sib;
    raddr = cmd.rd_sib ? (cur ^ NW'(1)) : idx;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.clr_wr) begin
      idx <= idx + NW'(1);
    end else if (cmd.load) begin
      if (in_operation == OP_ALLOC) begin
        idx <= NW'(1) << ld_depth;
      end else begin
        idx <= NW'(1);
      end
    end else if (cmd.scan_next) begin
      idx <= idx + NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= in_operation;
      faddr_q <= in_free_address;
      off     <= '0;
      if (in_operation == OP_ALLOC) begin
        depth <= ld_depth;
        step  <= SW'(1) << (int'(in_order) + PAGE_SHIFT);
      end else begin
        depth <= '0;
        step  <= SW'(1) << (SW - 1);
      end
    end else if (cmd.scan_next) begin
      if (level_end) begin
        // next tree level: blocks half as large
        depth <= depth + DW'(1);
        off   <= '0;
        step  <= step >> 1;
      end else begin
        off <= off + AW'(step);
      end
    end
    if (cmd.hit_save) begin
      hn        <= idx;
      hit_addr  <= node_addr;
      hit_depth <= depth;
      sw_idx    <= idx;
      sw_start  <= idx;
      sw_end    <= idx;
    end else if (cmd.sweep_wr) begin
      if (sw_idx == sw_end) begin
        sw_start <= sw_start << 1;
        sw_idx   <= sw_start << 1;
        sw_end   <= {sw_end[NW-2:0], 1'b1};
      end else begin
        sw_idx <= sw_idx + NW'(1);
      end
    end
    if (cmd.anc_init) begin
      ptr <= hn >> 1;
      cur <= hn;
    end else if (cmd.anc_wr) begin
      ptr <= ptr >> 1;
    end else if (cmd.merge_wr) begin
      cur <= ptr;
      ptr <= ptr >> 1;
    end
    if (cmd.res_load) begin
      status        <= cmd.res_status;
      block_address <= (cmd.res_status == ST_OK && op_q == OP_ALLOC) ? hit_addr : '0;
      freed_order   <= (cmd.res_status == ST_OK && op_q == OP_FREE) ?
                       4'(DW'(MAX_LEVEL) - hit_depth) : '0;
    end
  end

endmodule
`default_nettype wire
